// File: hdl/bresenham_line_rasterizer_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the Bresenham line rasterizer.
// Clocked on clk_i, and switched off while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef BRESENHAM_LINE_RASTERIZER_UNIT_ASSERT_SVH
`define BRESENHAM_LINE_RASTERIZER_UNIT_ASSERT_SVH

// Implication or plain property, checked at every rising edge outside reset.
`define BLR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The consequent is checked in the cycle after the trigger.
`define BLR_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/blr_pkg.sv
// ---------------------------------------------------------------------------
// blr_pkg
// Shared types and constants of the Bresenham line rasterizer.
// ---------------------------------------------------------------------------
`default_nettype none

package blr_pkg;

  // Default coordinate width in bits.
  localparam int unsigned COORD_BITS_DEF = 12;

  // Item kinds carried on the input tuser bit.
  typedef enum logic {
    KIND_START   = 1'b0,
    KIND_ADVANCE = 1'b1
  } kind_e;

  // Step direction of the minor axis.
  typedef enum logic [1:0] {
    MINOR_NONE = 2'b00,
    MINOR_UP   = 2'b01,
    MINOR_DOWN = 2'b11
  } minor_sign_e;

endpackage

`default_nettype wire

// File: hdl/blr_core.sv
// ---------------------------------------------------------------------------
// blr_core
// Line state registers and the single-step Bresenham update that produces
// one pixel per accepted word.
// ---------------------------------------------------------------------------
`default_nettype none

`include "bresenham_line_rasterizer_unit_assert.svh"

module blr_core #(
  parameter int unsigned CoordBits = blr_pkg::COORD_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 step_i,
  input  wire logic                 kind_i,
  input  wire logic [CoordBits-1:0] start_x_i,
  input  wire logic [CoordBits-1:0] start_y_i,
  input  wire logic [CoordBits-1:0] end_x_i,
  input  wire logic [CoordBits-1:0] end_y_i,
  output logic                      res_valid_o,
  output logic [CoordBits-1:0]      res_x_o,
  output logic [CoordBits-1:0]      res_y_o,
  output logic                      res_last_o
);

  localparam int unsigned ErrBits = CoordBits + 2;

  logic                      active_q, active_d;
  logic                      steep_q, steep_d;
  logic [CoordBits-1:0]      major_pos_q, major_pos_d;
  logic [CoordBits-1:0]      minor_pos_q, minor_pos_d;
  logic [CoordBits-1:0]      major_end_q, major_end_d;
  logic                      major_sign_q, major_sign_d;
  blr_pkg::minor_sign_e      minor_sign_q, minor_sign_d;
  logic [CoordBits-1:0]      major_delta_q, major_delta_d;
  logic [CoordBits-1:0]      minor_delta_q, minor_delta_d;
  logic [ErrBits-1:0]        error_q, error_d;

  logic [CoordBits-1:0]      adx, ady;
  logic                      st_steep;
  logic [CoordBits-1:0]      st_maj_s, st_maj_e, st_min_s, st_min_e, st_maj_d, st_min_d;
  logic [ErrBits-1:0]        adv_twice_min, adv_twice_maj;

  always_comb begin
    adx = (start_x_i >= end_x_i) ? (start_x_i - end_x_i) : (end_x_i - start_x_i);
    ady = (start_y_i >= end_y_i) ? (start_y_i - end_y_i) : (end_y_i - start_y_i);
    // A tie keeps x as the major axis.
    st_steep = (adx < ady);
    st_maj_s = st_steep ? start_y_i : start_x_i;
    st_maj_e = st_steep ? end_y_i   : end_x_i;
    st_min_s = st_steep ? start_x_i : start_y_i;
    st_min_e = st_steep ? end_x_i   : end_y_i;
    st_maj_d = st_steep ? ady : adx;
    st_min_d = st_steep ? adx : ady;

    adv_twice_min = {1'b0, minor_delta_q, 1'b0};
    adv_twice_maj = {1'b0, major_delta_q, 1'b0};

    active_d      = active_q;
    steep_d       = steep_q;
    major_pos_d   = major_pos_q;
    minor_pos_d   = minor_pos_q;
    major_end_d   = major_end_q;
    major_sign_d  = major_sign_q;
    minor_sign_d  = minor_sign_q;
    major_delta_d = major_delta_q;
    minor_delta_d = minor_delta_q;
    error_d       = error_q;

    if (kind_i == blr_pkg::KIND_START) begin
      steep_d       = st_steep;
      major_pos_d   = st_maj_s;
      minor_pos_d   = st_min_s;
      major_end_d   = st_maj_e;
      major_delta_d = st_maj_d;
      minor_delta_d = st_min_d;
      major_sign_d  = (st_maj_e < st_maj_s);
      if (st_min_e == st_min_s) begin
        minor_sign_d = blr_pkg::MINOR_NONE;
      end else if (st_min_e < st_min_s) begin
        minor_sign_d = blr_pkg::MINOR_DOWN;
      end else begin
        minor_sign_d = blr_pkg::MINOR_UP;
      end
      error_d  = {1'b0, st_min_d, 1'b0} - {2'b00, st_maj_d};
      active_d = (st_maj_s != st_maj_e);
    end else if (active_q) begin
      // The sign bit of the error term chooses whether the minor axis steps.
      if (error_q[ErrBits-1]) begin
        error_d = error_q + adv_twice_min;
      end else begin
        error_d = error_q + adv_twice_min - adv_twice_maj;
        case (minor_sign_q)
          blr_pkg::MINOR_UP:   minor_pos_d = minor_pos_q + 1'b1;
          blr_pkg::MINOR_DOWN: minor_pos_d = minor_pos_q - 1'b1;
          default:             minor_pos_d = minor_pos_q;
        endcase
      end
      major_pos_d = major_sign_q ? (major_pos_q - 1'b1) : (major_pos_q + 1'b1);
      active_d    = (major_pos_d != major_end_q);
    end

    // An advance with no line in progress gives an empty result.
    res_valid_o = (kind_i == blr_pkg::KIND_START) || active_q;
    res_x_o     = '0;
    res_y_o     = '0;
    res_last_o  = 1'b0;
    if (res_valid_o) begin
      res_x_o    = steep_d ? minor_pos_d : major_pos_d;
      res_y_o    = steep_d ? major_pos_d : minor_pos_d;
      res_last_o = !active_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q      <= 1'b0;
      steep_q       <= 1'b0;
      major_pos_q   <= '0;
      minor_pos_q   <= '0;
      major_end_q   <= '0;
      major_sign_q  <= 1'b0;
      minor_sign_q  <= blr_pkg::MINOR_NONE;
      major_delta_q <= '0;
      minor_delta_q <= '0;
      error_q       <= '0;
    end else if (step_i) begin
      active_q      <= active_d;
      steep_q       <= steep_d;
      major_pos_q   <= major_pos_d;
      minor_pos_q   <= minor_pos_d;
      major_end_q   <= major_end_d;
      major_sign_q  <= major_sign_d;
      minor_sign_q  <= minor_sign_d;
      major_delta_q <= major_delta_d;
      minor_delta_q <= minor_delta_d;
      error_q       <= error_d;
    end
  end

  // A pixel marked last always closes the line.
  `BLR_ASSERT_NEXT(a_last_ends_line, step_i && res_valid_o && res_last_o, !active_q,
    "line still active after its last pixel")

  // An advance with no line in progress must not disturb the state.
  `BLR_ASSERT_NEXT(a_idle_advance_stable,
    step_i && (kind_i == blr_pkg::KIND_ADVANCE) && !active_q,
    !active_q && $stable(major_pos_q) && $stable(minor_pos_q) && $stable(error_q),
    "idle advance changed the line state")

  // Every advance of an active line moves along the major axis.
  `BLR_ASSERT_NEXT(a_major_moves,
    step_i && (kind_i == blr_pkg::KIND_ADVANCE) && active_q,
    major_pos_q != $past(major_pos_q),
    "major position did not move on an advance")

  // The minor axis has no direction exactly when it has no extent.
  `BLR_ASSERT(a_minor_sign_delta,
    (minor_sign_q == blr_pkg::MINOR_NONE) == (minor_delta_q == '0),
    "minor step direction disagrees with minor delta")

endmodule

`default_nettype wire

// File: hdl/blr_out_stage.sv
// ---------------------------------------------------------------------------
// blr_out_stage
// Result register of the rasterizer. It holds one pixel word for the
// downstream side and is refilled in the cycle that word is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module blr_out_stage #(
  parameter int unsigned CoordBits = blr_pkg::COORD_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 load_i,
  input  wire logic                 res_valid_i,
  input  wire logic [CoordBits-1:0] res_x_i,
  input  wire logic [CoordBits-1:0] res_y_i,
  input  wire logic                 res_last_i,
  input  wire logic                 take_i,
  output logic                      space_o,
  output logic                      out_valid_o,
  output logic                      res_valid_o,
  output logic [CoordBits-1:0]      res_x_o,
  output logic [CoordBits-1:0]      res_y_o,
  output logic                      res_last_o
);

  logic                 out_valid_q, out_valid_d;
  logic                 res_valid_q;
  logic [CoordBits-1:0] res_x_q, res_y_q;
  logic                 res_last_q;

  // The register can take a new word when empty or when its word leaves now.
  assign space_o = !out_valid_q || take_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_i) begin
      out_valid_d = 1'b1;
    end else if (take_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_valid_q <= res_valid_i;
      res_x_q     <= res_x_i;
      res_y_q     <= res_y_i;
      res_last_q  <= res_last_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_valid_o = res_valid_q;
  assign res_x_o     = res_x_q;
  assign res_y_o     = res_y_q;
  assign res_last_o  = res_last_q;

endmodule

`default_nettype wire

// File: hdl/bresenham_line_rasterizer_unit.sv
// ---------------------------------------------------------------------------
// bresenham_line_rasterizer_unit
// Integer Bresenham line rasterizer with stream input and output.
// ---------------------------------------------------------------------------
// Each input word is either a start (tuser low), which loads two endpoints
// and yields the first pixel, or an advance (tuser high), which yields the
// next pixel of the current line; the pixel that reaches the second endpoint
// has tlast set. An advance with no line in progress yields a word with tuser
// low and zero coordinates. The block takes one word per clock while the
// result register has space, and returns its pixel in the next cycle from
// the result register; the line state is updated by one add on the error
// term and the coordinate steps. While the result register is full and not
// taken, s_axis_tready is low.
`default_nettype none

module bresenham_line_rasterizer_unit #(
  parameter int unsigned  CoordBits = blr_pkg::COORD_BITS_DEF,
  localparam int unsigned InWidth   = ((4 * CoordBits + 7) / 8) * 8,
  localparam int unsigned OutWidth  = ((2 * CoordBits + 7) / 8) * 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // start_x, start_y, end_x, end_y from bit 0 up, zero filled to whole bytes
  input  wire logic [InWidth-1:0]   s_axis_tdata,
  // kind
  input  wire logic                 s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // pixel_x, pixel_y from bit 0 up, zero filled to whole bytes
  output logic [OutWidth-1:0]       m_axis_tdata,
  // valid_res
  output logic                      m_axis_tuser,
  // last
  output logic                      m_axis_tlast
);

  logic                 step;
  logic                 space;
  logic                 core_valid, core_last;
  logic [CoordBits-1:0] core_x, core_y;
  logic [CoordBits-1:0] out_x, out_y;

  assign s_axis_tready = space;
  assign step          = s_axis_tvalid && space;

  blr_core #(
    .CoordBits (CoordBits)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .kind_i      (s_axis_tuser),
    .start_x_i   (s_axis_tdata[CoordBits-1:0]),
    .start_y_i   (s_axis_tdata[2*CoordBits-1:CoordBits]),
    .end_x_i     (s_axis_tdata[3*CoordBits-1:2*CoordBits]),
    .end_y_i     (s_axis_tdata[4*CoordBits-1:3*CoordBits]),
    .res_valid_o (core_valid),
    .res_x_o     (core_x),
    .res_y_o     (core_y),
    .res_last_o  (core_last)
  );

  blr_out_stage #(
    .CoordBits (CoordBits)
  ) u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .res_valid_i (core_valid),
    .res_x_i     (core_x),
    .res_y_i     (core_y),
    .res_last_i  (core_last),
    .take_i      (m_axis_tready),
    .space_o     (space),
    .out_valid_o (m_axis_tvalid),
    .res_valid_o (m_axis_tuser),
    .res_x_o     (out_x),
    .res_y_o     (out_y),
    .res_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = OutWidth'({out_y, out_x});

endmodule

`default_nettype wire
